### design/rafp_pkg.sv
// ----------------------------------------------------------------------------
// rafp_pkg
// Types and constants shared by the route advertisement parser modules.
// ----------------------------------------------------------------------------
package rafp_pkg;

    localparam logic [7:0] TYPE_MARKER  = 8'h01;
    localparam logic [9:0] HDR_END_POS  = 10'd15;   // last byte of the fixed header
    localparam logic [9:0] COUNT_POS    = 10'd16;
    localparam logic [9:0] INDEX_MAX    = 10'd1023;
    localparam logic [7:0] COST_RESET   = 8'd16;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        K_HEADER  = 3'd0,
        K_ROUTE   = 3'd1,
        K_OK      = 3'd2,
        K_SHORT   = 3'd3,
        K_BADTYPE = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind        kind;
        logic [7:0]   source_router;
        logic [15:0]  source_locator;
        logic [63:0]  source_extended;
        logic [31:0]  sequence_count;
        logic [7:0]   announced_routes;
        logic [7:0]   entry_router;
        logic [7:0]   entry_cost;
        logic         entry_reachable;
        logic [7:0]   routes_delivered;
        logic         run_last;
    } t_result;

    // Results produced by one byte: num is 0, 1 or 2, res[0] goes out first.
    typedef struct packed {
        logic [1:0]        num;
        t_result [1:0]     res;
    } t_push;

endpackage

### design/rafp_parser.sv
// ----------------------------------------------------------------------------
// rafp_parser
// Input register, message state and result building for one byte per cycle while the queue has room.
// ----------------------------------------------------------------------------
module rafp_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last_byte,
    input  logic             i_cfg_wr_en,
    input  logic [7:0]       i_cfg_wr_data,
    input  logic             i_space_ok,
    output rafp_pkg::t_push  o_push
);
    import rafp_pkg::*;

    logic         r_in_valid;
    logic [7:0]   r_in_data;
    logic         r_in_last;
    logic [7:0]   r_infinite_cost;

    logic [9:0]   r_byte_index;
    logic         r_type_good;
    logic [7:0]   r_router;
    logic [15:0]  r_locator;
    logic [63:0]  r_extended;
    logic [31:0]  r_sequence;
    logic [7:0]   r_count;
    logic [7:0]   r_delivered;
    logic [7:0]   r_pair_first;

    logic         n_type_good;
    logic [7:0]   n_router;
    logic [15:0]  n_locator;
    logic [63:0]  n_extended;
    logic [31:0]  n_sequence;
    logic [7:0]   n_count;
    logic [7:0]   n_delivered;
    logic [7:0]   n_pair_first;

    logic         fire;
    logic         route_hit;
    logic         header_hit;
    logic [2:0]   ext_idx;
    logic [5:0]   ext_sel;
    logic [4:0]   seq_sel;
    t_result      src_res;
    t_result      first_res;
    t_result      end_res;

    assign fire       = r_in_valid && i_space_ok;
    assign o_in_ready = !r_in_valid || fire;

    assign ext_idx = r_byte_index[2:0] - 3'd4;
    assign ext_sel = {ext_idx, 3'b000};
    assign seq_sel = {r_byte_index[1:0], 3'b000};

    // Field capture. Every header position is written once per message into
    // cleared registers, so a plain byte write matches the OR-assembly.
    always_comb begin
        n_type_good  = r_type_good;
        n_router     = r_router;
        n_locator    = r_locator;
        n_extended   = r_extended;
        n_sequence   = r_sequence;
        n_count      = r_count;
        n_delivered  = r_delivered;
        n_pair_first = r_pair_first;
        route_hit    = 1'b0;
        if (r_byte_index == 10'd0) begin
            n_type_good = (r_in_data == TYPE_MARKER);
        end else if (r_byte_index == 10'd1) begin
            n_router = r_in_data;
        end else if (r_byte_index <= 10'd3) begin
            if (r_byte_index[0]) begin
                n_locator[15:8] = r_in_data;
            end else begin
                n_locator[7:0] = r_in_data;
            end
        end else if (r_byte_index <= 10'd11) begin
            n_extended[ext_sel +: 8] = r_in_data;
        end else if (r_byte_index <= HDR_END_POS) begin
            n_sequence[seq_sel +: 8] = r_in_data;
        end else if (r_byte_index == COUNT_POS) begin
            n_count = r_in_data;
        end else if (r_byte_index != INDEX_MAX) begin
            if (r_byte_index[0]) begin
                n_pair_first = r_in_data;
            end else if (r_type_good && (r_delivered < r_count)) begin
                n_delivered = r_delivered + 8'd1;
                route_hit   = 1'b1;
            end
        end
    end

    assign header_hit = n_type_good &&
                        ((r_byte_index == COUNT_POS) ||
                         ((r_byte_index == HDR_END_POS) && r_in_last));

    always_comb begin
        src_res                  = '0;
        src_res.kind             = K_HEADER;
        src_res.source_router    = n_router;
        src_res.source_locator   = n_locator;
        src_res.source_extended  = n_extended;
        src_res.sequence_count   = n_sequence;
        src_res.announced_routes = n_count;

        first_res = src_res;
        if (route_hit) begin
            first_res.kind             = K_ROUTE;
            first_res.entry_router     = r_pair_first;
            first_res.entry_cost       = r_in_data;
            first_res.entry_reachable  = (r_in_data < r_infinite_cost);
            first_res.routes_delivered = n_delivered;
        end

        // A failed message reports no sender fields.
        if (r_byte_index < HDR_END_POS) begin
            end_res      = '0;
            end_res.kind = K_SHORT;
        end else if (!n_type_good) begin
            end_res      = '0;
            end_res.kind = K_BADTYPE;
        end else begin
            end_res      = src_res;
            end_res.kind = K_OK;
        end
        end_res.routes_delivered = n_delivered;
        end_res.run_last         = 1'b1;

        o_push = '0;
        if (fire) begin
            o_push.num = {1'b0, route_hit || header_hit} + {1'b0, r_in_last};
        end
        o_push.res[0] = (route_hit || header_hit) ? first_res : end_res;
        o_push.res[1] = end_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_infinite_cost <= COST_RESET;
        end else if (i_cfg_wr_en) begin
            r_infinite_cost <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= '0;
            r_type_good  <= 1'b0;
            r_router     <= '0;
            r_locator    <= '0;
            r_extended   <= '0;
            r_sequence   <= '0;
            r_count      <= '0;
            r_delivered  <= '0;
            r_pair_first <= '0;
        end else if (fire) begin
            if (r_in_last) begin
                r_byte_index <= '0;
                r_type_good  <= 1'b0;
                r_router     <= '0;
                r_locator    <= '0;
                r_extended   <= '0;
                r_sequence   <= '0;
                r_count      <= '0;
                r_delivered  <= '0;
                r_pair_first <= '0;
            end else begin
                if (r_byte_index != INDEX_MAX) begin
                    r_byte_index <= r_byte_index + 10'd1;
                end
                r_type_good  <= n_type_good;
                r_router     <= n_router;
                r_locator    <= n_locator;
                r_extended   <= n_extended;
                r_sequence   <= n_sequence;
                r_count      <= n_count;
                r_delivered  <= n_delivered;
                r_pair_first <= n_pair_first;
            end
        end
    end

    a_index_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_last) |=> (r_byte_index == 10'd0 && r_delivered == 8'd0))
        else $error("message state not cleared after final byte");

    a_end_goes_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.num == 2'd2) |-> (r_in_last && !o_push.res[0].run_last))
        else $error("end-of-message result not placed last");

    a_routes_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.num != 2'd0 && o_push.res[0].kind == K_ROUTE) |->
            (o_push.res[0].routes_delivered <= o_push.res[0].announced_routes))
        else $error("more routes delivered than announced");

endmodule

### design/rafp_out_queue.sv
// ----------------------------------------------------------------------------
// rafp_out_queue
// Small result queue: takes up to two results a cycle, hands out one while the reader is ready.
// ----------------------------------------------------------------------------
module rafp_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rafp_pkg::t_push    i_push,
    output logic               o_space_ok,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rafp_pkg::t_result  o_result
);
    import rafp_pkg::*;

    t_result               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]    r_wptr;
    logic [Q_PTR_W-1:0]    r_rptr;
    logic [Q_CNT_W-1:0]    r_count;
    logic                  pop;
    logic [Q_PTR_W-1:0]    wptr_next;

    assign pop         = o_out_valid && i_out_ready;
    assign o_out_valid = (r_count != '0);
    assign o_result    = r_mem[r_rptr];
    // Room for the worst case of two results from one byte.
    assign o_space_ok  = (r_count <= Q_CNT_W'(Q_DEPTH - 2));
    assign wptr_next   = r_wptr + {{(Q_PTR_W-1){1'b0}}, 1'b1};

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wptr] <= i_push.res[0];
        end
        if (i_push.num == 2'd2) begin
            r_mem[wptr_next] <= i_push.res[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + Q_PTR_W'(i_push.num);
            r_count <= r_count + Q_CNT_W'(i_push.num) - Q_CNT_W'(pop);
            if (pop) begin
                r_rptr <= r_rptr + {{(Q_PTR_W-1){1'b0}}, 1'b1};
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.num != 2'd0) |-> o_space_ok)
        else $error("results pushed without room");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_push.num == 2'd0) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count did not drop on a lone read");

endmodule

### design/route_advert_frame_parser.sv
// ----------------------------------------------------------------------------
// route_advert_frame_parser
// Routing advertisement parser: header fields, route entries, end status.
// ----------------------------------------------------------------------------
// The block takes one message byte per transaction and accepts a byte in every
// cycle while the output queue has room. A byte is held in the input register,
// where captured fields and counters are updated; its results are written into
// a four-entry output queue, from which the first result can be taken. Most
// bytes give at most one result; the final byte can give two (a header or route
// followed by the end status), and the queue then drains one result per cycle
// while the reader is ready. A byte leaves the input register only while the
// queue holds two or fewer results, the only thing that slows intake. The
// unreachable-cost limit resets to 16; the user writes it via the configuration
// port while no message is in flight, which the block itself does not enforce.
module route_advert_frame_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [7:0]    i_cfg_wr_data,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [7:0]    i_data_byte,
    input  logic          i_last_byte,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [2:0]    o_result_kind,
    output logic [7:0]    o_source_router,
    output logic [15:0]   o_source_locator,
    output logic [63:0]   o_source_extended,
    output logic [31:0]   o_sequence_count,
    output logic [7:0]    o_announced_routes,
    output logic [7:0]    o_entry_router,
    output logic [7:0]    o_entry_cost,
    output logic          o_entry_reachable,
    output logic [7:0]    o_routes_delivered,
    output logic          o_run_last
);
    import rafp_pkg::*;

    t_push    push;
    t_result  result;
    logic     space_ok;

    rafp_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_space_ok    (space_ok),
        .o_push        (push)
    );

    rafp_out_queue u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_space_ok  (space_ok),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    assign o_result_kind      = result.kind;
    assign o_source_router    = result.source_router;
    assign o_source_locator   = result.source_locator;
    assign o_source_extended  = result.source_extended;
    assign o_sequence_count   = result.sequence_count;
    assign o_announced_routes = result.announced_routes;
    assign o_entry_router     = result.entry_router;
    assign o_entry_cost       = result.entry_cost;
    assign o_entry_reachable  = result.entry_reachable;
    assign o_routes_delivered = result.routes_delivered;
    assign o_run_last         = result.run_last;

endmodule
